// File: hdl/pmtu_pkg.sv
// pmtu_pkg: shared types, constants and plateau table for the path MTU cache.
// No dependencies.
`default_nettype none
package pmtu_pkg;
  localparam int ENTRIES_DEF = 16;
  localparam int PLATEAUS = 11;

  localparam logic [2:0] FN_EST     = 3'd0;
  localparam logic [2:0] FN_PROBE   = 3'd1;
  localparam logic [2:0] FN_CONFIRM = 3'd2;
  localparam logic [2:0] FN_REPORT  = 3'd3;
  localparam logic [2:0] FN_PURGE   = 3'd4;
  localparam logic [2:0] FN_CLEAR   = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SAME    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [1:0] CFG_PROBE_INT = 2'd0;
  localparam logic [1:0] CFG_RETRY_INT = 2'd1;
  localparam logic [1:0] CFG_MIN_MTU   = 2'd2;

  // plateau i; the last one is the min_mtu register
  function automatic logic [15:0] plateau(input logic [3:0] i, input logic [9:0] min_mtu);
    case (i)
      4'd0: plateau = 16'd65535;
      4'd1: plateau = 16'd32000;
      4'd2: plateau = 16'd17914;
      4'd3: plateau = 16'd8166;
      4'd4: plateau = 16'd4352;
      4'd5: plateau = 16'd2002;
      4'd6: plateau = 16'd1492;
      4'd7: plateau = 16'd1006;
      4'd8: plateau = 16'd508;
      4'd9: plateau = 16'd296;
      default: plateau = {6'd0, min_mtu};
    endcase
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture request
    logic scan_clr;   // reset scan index
    logic scan_step;  // advance scan index
    logic pl_clr;     // reset plateau index
    logic pl_step;    // advance plateau index
    logic exec;       // apply the operation
    logic done;       // register result
  } pmtu_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;
    logic pl_last;
  } pmtu_stat_t;
endpackage
`default_nettype wire

// File: hdl/pmtu_ctrl.sv
// pmtu_ctrl: sequencer for the path MTU cache.
// Depends on pmtu_pkg.
`default_nettype none
module pmtu_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output pmtu_pkg::pmtu_cmd_t      cmd,
  input  wire pmtu_pkg::pmtu_stat_t stat
);
  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_PLAT, S_EXEC, S_DONE} state_t;
  state_t state;

  always_comb begin
    cmd = '0;
    in_ready = (state == S_IDLE) && !out_valid && !rst;
    cmd.load = in_valid && in_ready;
    cmd.scan_clr = cmd.load;
    cmd.pl_clr = cmd.load;
    cmd.scan_step = (state == S_SCAN);
    cmd.pl_step = (state == S_PLAT);
    cmd.exec = (state == S_EXEC);
    cmd.done = (state == S_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (cmd.load) state <= S_SCAN;
        S_SCAN: if (stat.scan_last) state <= S_PLAT;
        S_PLAT: if (stat.pl_last) state <= S_EXEC;
        S_EXEC: state <= S_DONE;
        S_DONE: begin
          state <= S_IDLE;
          out_valid <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("accept while busy");
  a_done_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |=> out_valid) else $error("result lost");
  a_exec_seq: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |=> (state == S_DONE)) else $error("bad sequence");
endmodule
`default_nettype wire

// File: hdl/pmtu_dp.sv
// pmtu_dp: entry table, scan and plateau search datapath.
// Depends on pmtu_pkg.
`default_nettype none
module pmtu_dp #(
  parameter int ENTRIES = pmtu_pkg::ENTRIES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire pmtu_pkg::pmtu_cmd_t cmd,
  output pmtu_pkg::pmtu_stat_t     stat,
  input  wire logic                cfg_valid,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [31:0]         cfg_data,
  input  wire logic [2:0]          func,
  input  wire logic [31:0]         destination,
  input  wire logic [15:0]         iface_id,
  input  wire logic [15:0]         hop_mtu,
  input  wire logic [15:0]         icmp_mtu,
  input  wire logic [15:0]         quoted_length,
  input  wire logic [15:0]         send_length,
  input  wire logic [31:0]         now_ticks,
  output logic [15:0]              mtu_out,
  output logic [1:0]               status,
  output logic [4:0]               entry_count
);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  logic [31:0] probe_interval, probe_retry_interval;
  logic [9:0]  min_mtu;

  logic [ENTRIES-1:0] vbits;
  logic [31:0] dest_store [ENTRIES];
  logic [15:0] iface_store [ENTRIES];
  logic [15:0] mtu_store [ENTRIES];
  logic [15:0] probe_store [ENTRIES];
  logic [31:0] probe_time_store [ENTRIES];

  logic [2:0]  r_func;
  logic [31:0] r_dst, r_now;
  logic [15:0] r_ifc, r_fh, r_rep, r_quoted, r_slen;

  logic [IW-1:0] scan;
  logic          hit, free_ok;
  logic [IW-1:0] hit_idx, free_idx;
  logic [CW-1:0] count;

  logic [3:0]  pl;
  logic        below_found, above_found;
  logic [15:0] below_val, above_val;

  // matched entry fields
  logic [15:0] e_mtu, e_probe, cur;
  logic [31:0] e_ptime;
  logic [15:0] pval;

  always_comb begin
    e_mtu = mtu_store[hit_idx];
    e_probe = probe_store[hit_idx];
    e_ptime = probe_time_store[hit_idx];
    cur = hit ? ((e_mtu < r_fh) ? e_mtu : r_fh) : r_fh;
    pval = pmtu_pkg::plateau(pl, min_mtu);
    stat.scan_last = (scan == IW'(ENTRIES - 1));
    stat.pl_last = (pl == 4'(pmtu_pkg::PLATEAUS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_interval <= 32'd600;
      probe_retry_interval <= 32'd120;
      min_mtu <= 10'd576;
    end else if (cfg_valid) begin
      case (cfg_index)
        pmtu_pkg::CFG_PROBE_INT: probe_interval <= cfg_data;
        pmtu_pkg::CFG_RETRY_INT: probe_retry_interval <= cfg_data;
        pmtu_pkg::CFG_MIN_MTU:   min_mtu <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // scan: first match, first free slot; plateau: both searches in one pass
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_func <= func; r_dst <= destination; r_ifc <= iface_id;
      r_fh <= hop_mtu; r_rep <= icmp_mtu; r_quoted <= quoted_length;
      r_slen <= send_length; r_now <= now_ticks;
    end
    if (cmd.scan_clr) begin
      scan <= '0; hit <= 1'b0; free_ok <= 1'b0;
      hit_idx <= '0; free_idx <= '0;
    end else if (cmd.scan_step) begin
      if (!stat.scan_last) scan <= scan + IW'(1);
      if (!hit && vbits[scan] && dest_store[scan] == r_dst && iface_store[scan] == r_ifc) begin
        hit <= 1'b1; hit_idx <= scan;
      end
      if (!free_ok && !vbits[scan]) begin
        free_ok <= 1'b1; free_idx <= scan;
      end
    end
    if (cmd.pl_clr) begin
      pl <= '0; below_found <= 1'b0; above_found <= 1'b0;
      below_val <= '0; above_val <= '0;
    end else if (cmd.pl_step) begin
      if (!stat.pl_last) pl <= pl + 4'd1;
      if (!below_found && pval < r_quoted) begin
        below_found <= 1'b1; below_val <= pval;
      end
      // last hit in forward order is the first from the end
      if (pval > cur) begin
        above_found <= 1'b1; above_val <= pval;
      end
    end
  end

  // operation
  logic [15:0] cand, up;
  logic [15:0] res_mtu;
  logic [1:0]  res_st;
  logic        rep_bad;
  always_comb begin
    cand = (r_rep == 16'd0) ? below_val : r_rep;
    up = above_found ? ((above_val < r_fh) ? above_val : r_fh) : r_fh;
    rep_bad = (r_dst == 32'd0) || (r_ifc == 16'd0) || (r_fh < {6'd0, min_mtu}) ||
              (r_quoted < {6'd0, min_mtu}) || (cand < {6'd0, min_mtu});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vbits <= '0;
    end else if (cmd.exec) begin
      res_mtu <= 16'd0;
      res_st <= pmtu_pkg::ST_OK;
      case (r_func)
        pmtu_pkg::FN_EST: res_mtu <= cur;
        pmtu_pkg::FN_PROBE: begin
          res_mtu <= cur;
          if (hit && !(e_ptime > r_now) && up > cur && !(r_slen < up)) begin
            probe_store[hit_idx] <= up;
            probe_time_store[hit_idx] <= pmtu_pkg::sat_add(r_now, probe_retry_interval);
            res_mtu <= up;
          end
        end
        pmtu_pkg::FN_CONFIRM: begin
          if (!hit || e_probe <= e_mtu) res_st <= pmtu_pkg::ST_SAME;
          else begin
            mtu_store[hit_idx] <= e_probe;
            probe_store[hit_idx] <= 16'd0;
            probe_time_store[hit_idx] <= pmtu_pkg::sat_add(r_now, probe_interval);
          end
        end
        pmtu_pkg::FN_REPORT: begin
          if (rep_bad) res_st <= pmtu_pkg::ST_INVALID;
          else if (cand >= cur) begin
            res_st <= pmtu_pkg::ST_SAME;
            if (hit) begin
              probe_store[hit_idx] <= 16'd0;
              probe_time_store[hit_idx] <= pmtu_pkg::sat_add(r_now, probe_interval);
            end
          end else if (!hit && !free_ok) res_st <= pmtu_pkg::ST_FULL;
          else begin
            vbits[hit ? hit_idx : free_idx] <= 1'b1;
            dest_store[hit ? hit_idx : free_idx] <= r_dst;
            iface_store[hit ? hit_idx : free_idx] <= r_ifc;
            mtu_store[hit ? hit_idx : free_idx] <= cand;
            probe_store[hit ? hit_idx : free_idx] <= 16'd0;
            probe_time_store[hit ? hit_idx : free_idx] <=
              pmtu_pkg::sat_add(r_now, probe_interval);
          end
        end
        pmtu_pkg::FN_PURGE: begin
          for (int i = 0; i < ENTRIES; i++)
            if (vbits[i] && iface_store[i] == r_ifc) vbits[i] <= 1'b0;
        end
        pmtu_pkg::FN_CLEAR: vbits <= '0;
        default: ;
      endcase
    end
  end

  // occupancy snapshot taken at DONE, checked below against the valid bits
  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else if (cmd.done) count <= CW'($countones(vbits));
  end

  always_ff @(posedge clk) begin
    if (cmd.done) begin
      mtu_out <= res_mtu;
      status <= res_st;
      entry_count <= 5'(CW'($countones(vbits)));
    end
  end

  a_count: assert property (@(posedge clk) disable iff (rst)
    cmd.done |=> (count == CW'($countones(vbits)))) else $error("count mismatch");
endmodule
`default_nettype wire

// File: hdl/path_mtu_cache.sv
// path_mtu_cache: RFC 1191 path MTU cache, controller plus datapath.
// Sequence: after the accepting edge, a one-entry-a-cycle table scan, an eleven-step plateau
// search, execute, then result (DONE registers it and raises out_valid).
// One request at a time, taken the cycle after the result goes.
// Reset (rst, synchronous): table empty, registers 600 / 120 / 576, no handshake taken.
// Depends on pmtu_pkg, pmtu_ctrl, pmtu_dp.
`default_nettype none
module path_mtu_cache #(
  parameter int ENTRIES = pmtu_pkg::ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  func,
  input  wire logic [31:0] destination,
  input  wire logic [15:0] iface_id,
  input  wire logic [15:0] hop_mtu,
  input  wire logic [15:0] icmp_mtu,
  input  wire logic [15:0] quoted_length,
  input  wire logic [15:0] send_length,
  input  wire logic [31:0] now_ticks,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      mtu_out,
  output logic [1:0]       status,
  output logic [4:0]       entry_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  pmtu_pkg::pmtu_cmd_t  cmd;
  pmtu_pkg::pmtu_stat_t stat;

  // configuration is taken whenever out of reset
  assign cfg_ready = !rst;

  pmtu_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .stat
  );

  pmtu_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk, .rst, .cmd, .stat, .cfg_valid, .cfg_index, .cfg_data,
    .func, .destination, .iface_id, .hop_mtu, .icmp_mtu,
    .quoted_length, .send_length, .now_ticks, .mtu_out, .status, .entry_count
  );
endmodule
`default_nettype wire
